/* sv/png_metadata_chunk_filter_unit_assert.svh */
// assertion macros for the png metadata chunk filter checker
// expects clk_i and rst_ni in the scope of every use
`ifndef PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH
`define PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH

// checked only while out of reset
`define PMCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define PMCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/pmcf_pkg.sv */
// shared types, constants and tag helpers of the png metadata chunk filter
// no dependencies
package pmcf_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned HOLD_DEPTH = 12;

  localparam logic [3:0] SIG_LAST = 4'd7;
  localparam logic [3:0] HDR_LAST = 4'd11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [31:0] TAG_EXIF = 32'h6558_4966;
  localparam logic [31:0] TAG_ICCP = 32'h6943_4350;
  localparam logic [31:0] TAG_ITXT = 32'h6954_5874;
  localparam logic [31:0] TAG_TEXT = 32'h7445_5874;
  localparam logic [31:0] TAG_ZTXT = 32'h7a54_5874;
  localparam logic [31:0] TAG_TIME = 32'h7449_4d45;
  localparam logic [31:0] TAG_IEND = 32'h4945_4e44;

  typedef enum logic [4:0] {
    PH_SIG  = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_BODY = 5'b00100,
    PH_TAIL = 5'b01000,
    PH_BAD  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    K_PASS  = 2'd0,
    K_FLUSH = 2'd1,
    K_STAT  = 2'd2
  } kind_e;

  // one queue entry: what the back part has to emit for one accepted byte
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       bank;
    logic       hdr;     // flush of 12 header bytes, else 8 signature bytes
    logic       last;
    logic [1:0] status;
  } q_ent_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [3:0] idx;
    logic [7:0] data;
  } hold_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4e;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0d;
      3'd5: r = 8'h0a;
      3'd6: r = 8'h1a;
      3'd7: r = 8'h0a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic tag_dropped(input logic [31:0] tag);
    return (tag == TAG_EXIF) || (tag == TAG_ICCP) || (tag == TAG_ITXT) ||
           (tag == TAG_TEXT) || (tag == TAG_ZTXT) || (tag == TAG_TIME);
  endfunction

endpackage

/* sv/pmcf_fifo.sv */
// short request queue between the classifying front part and the output back part
// depends on pmcf_pkg
module pmcf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pmcf_pkg::q_ent_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pmcf_pkg::q_ent_t pop_data_o,
  output logic            empty_o
);

  pmcf_pkg::q_ent_t mem_q [pmcf_pkg::FIFO_DEPTH];
  logic [pmcf_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [pmcf_pkg::FIFO_AW:0]   cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (pmcf_pkg::FIFO_AW+1)'(pmcf_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/pmcf_front.sv */
// front part: accepts file bytes, tracks signature and chunk framing, queues work
// depends on pmcf_pkg
module pmcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output pmcf_pkg::q_ent_t    push_data_o,
  output pmcf_pkg::hold_wr_t  hold_wr_o,
  input  pmcf_pkg::bank_rel_t rel_i
);

  pmcf_pkg::phase_e phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        sig_bad_q, sig_bad_d;
  logic        keep_q, keep_d;
  logic        iend_q, iend_d;
  logic        bank_q, bank_d;
  logic [1:0]  pend_q, pend_d;
  logic [31:0] len_q, len_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] remain_q, remain_d;

  logic accept, hold_ph, mis, keep_n, iend_n, done;

  assign hold_ph    = (phase_q == pmcf_pkg::PH_SIG) || (phase_q == pmcf_pkg::PH_HDR);
  // a new header may not overwrite a bank that is still being flushed
  assign in_ready_o = ~fifo_full_i & ~(hold_ph & pend_q[bank_q]);
  assign accept     = in_valid_i & in_ready_o;

  assign mis    = sig_bad_q | (in_byte_i != pmcf_pkg::sig_byte(cnt_q[2:0]));
  assign keep_n = ~pmcf_pkg::tag_dropped(tag_q);
  assign iend_n = (tag_q == pmcf_pkg::TAG_IEND);
  assign done   = (remain_q == 32'd1);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sig_bad_d = sig_bad_q;
    keep_d    = keep_q;
    iend_d    = iend_q;
    bank_d    = bank_q;
    pend_d    = pend_q;
    len_d     = len_q;
    tag_d     = tag_q;
    remain_d  = remain_q;
    push_o    = 1'b0;
    push_data_o = '{kind: pmcf_pkg::K_PASS, data: in_byte_i, bank: bank_q, hdr: 1'b0,
                    last: in_last_i, status: pmcf_pkg::ST_OK};
    hold_wr_o = '{en: 1'b0, bank: bank_q, idx: cnt_q, data: in_byte_i};

    if (rel_i.en) pend_d[rel_i.bank] = 1'b0;

    if (accept) begin
      unique case (phase_q)
        pmcf_pkg::PH_SIG: begin
          hold_wr_o.en = 1'b1;
          sig_bad_d    = mis;
          if (cnt_q == pmcf_pkg::SIG_LAST) begin
            cnt_d = '0;
            if (!mis) begin
              push_o = 1'b1;
              push_data_o.kind = pmcf_pkg::K_FLUSH;
              phase_d = pmcf_pkg::PH_HDR;
            end else begin
              phase_d = pmcf_pkg::PH_BAD;
              if (in_last_i) begin
                push_o = 1'b1;
                push_data_o.kind   = pmcf_pkg::K_STAT;
                push_data_o.status = pmcf_pkg::ST_BAD_SIG;
              end
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (in_last_i) begin
              push_o = 1'b1;
              push_data_o.kind   = pmcf_pkg::K_STAT;
              push_data_o.status = pmcf_pkg::ST_BAD_SIG;
            end
          end
        end
        pmcf_pkg::PH_HDR: begin
          hold_wr_o.en = 1'b1;
          if (cnt_q[3:2] == 2'b00) len_d = {len_q[23:0], in_byte_i};
          if (cnt_q[3:2] == 2'b01) tag_d = {tag_q[23:0], in_byte_i};
          if (cnt_q == pmcf_pkg::HDR_LAST) begin
            cnt_d    = '0;
            keep_d   = keep_n;
            iend_d   = iend_n;
            remain_d = len_q;
            push_data_o.hdr = 1'b1;
            if (len_q == '0) begin
              phase_d = iend_n ? pmcf_pkg::PH_TAIL : pmcf_pkg::PH_HDR;
              if (keep_n) begin
                push_o = 1'b1;
                push_data_o.kind = pmcf_pkg::K_FLUSH;
              end else if (in_last_i) begin
                push_o = 1'b1;
                push_data_o.kind = pmcf_pkg::K_STAT;
              end
            end else begin
              phase_d = pmcf_pkg::PH_BODY;
              if (in_last_i) begin
                // chunk cut off right after its header: status only
                push_o = 1'b1;
                push_data_o.kind   = pmcf_pkg::K_STAT;
                push_data_o.status = pmcf_pkg::ST_TRUNC;
              end else if (keep_n) begin
                push_o = 1'b1;
                push_data_o.kind = pmcf_pkg::K_FLUSH;
              end
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (in_last_i) begin
              // trailing fragment is dropped
              push_o = 1'b1;
              push_data_o.kind = pmcf_pkg::K_STAT;
            end
          end
        end
        pmcf_pkg::PH_BODY: begin
          if (done) begin
            phase_d = iend_q ? pmcf_pkg::PH_TAIL : pmcf_pkg::PH_HDR;
          end
          remain_d = remain_q - 1'b1;
          if (in_last_i) begin
            push_o = 1'b1;
            if (!done) begin
              push_data_o.kind   = pmcf_pkg::K_STAT;
              push_data_o.status = pmcf_pkg::ST_TRUNC;
            end else if (!keep_q) begin
              push_data_o.kind = pmcf_pkg::K_STAT;
            end
          end else begin
            push_o = keep_q;
          end
        end
        pmcf_pkg::PH_TAIL: begin
          if (in_last_i) begin
            push_o = 1'b1;
            push_data_o.kind = pmcf_pkg::K_STAT;
          end
        end
        pmcf_pkg::PH_BAD: begin
          if (in_last_i) begin
            push_o = 1'b1;
            push_data_o.kind   = pmcf_pkg::K_STAT;
            push_data_o.status = pmcf_pkg::ST_BAD_SIG;
          end
        end
        default: begin
          phase_d = pmcf_pkg::PH_BAD;
        end
      endcase

      if (push_o && push_data_o.kind == pmcf_pkg::K_FLUSH) begin
        pend_d[bank_q] = 1'b1;
        bank_d = ~bank_q;
      end
      if (push_data_o.kind != pmcf_pkg::K_STAT) push_data_o.status = pmcf_pkg::ST_OK;

      // end of file: back to the signature phase for the next one
      if (in_last_i) begin
        phase_d   = pmcf_pkg::PH_SIG;
        cnt_d     = '0;
        sig_bad_d = 1'b0;
        keep_d    = 1'b0;
        iend_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pmcf_pkg::PH_SIG;
      cnt_q     <= '0;
      sig_bad_q <= 1'b0;
      keep_q    <= 1'b0;
      iend_q    <= 1'b0;
      bank_q    <= 1'b0;
      pend_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      sig_bad_q <= sig_bad_d;
      keep_q    <= keep_d;
      iend_q    <= iend_d;
      bank_q    <= bank_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    tag_q    <= tag_d;
    remain_q <= remain_d;
  end

endmodule

/* sv/pmcf_back.sv */
// back part: ping-pong hold store and output register, emits one item per cycle
// while the output is not stalled and the queue is not empty; depends on pmcf_pkg
module pmcf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  pmcf_pkg::q_ent_t    fifo_data_i,
  output logic                pop_o,
  input  pmcf_pkg::hold_wr_t  hold_wr_i,
  output pmcf_pkg::bank_rel_t rel_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_dvalid_o,
  output logic                out_last_o,
  output logic [1:0]          out_status_o
);

  logic [7:0] hold_q [2][pmcf_pkg::HOLD_DEPTH];

  logic       vld_q;
  logic [3:0] idx_q, idx_d;
  logic [7:0] byte_q, byte_d;
  logic       dv_q, dv_d;
  logic       last_q, last_d;
  logic [1:0] st_q, st_d;
  logic       load, fl_end;

  assign load   = (~vld_q | out_ready_i) & ~fifo_empty_i;
  assign fl_end = fifo_data_i.hdr ? (idx_q == pmcf_pkg::HDR_LAST)
                                  : (idx_q == pmcf_pkg::SIG_LAST);

  always_comb begin
    idx_d  = idx_q;
    byte_d = byte_q;
    dv_d   = dv_q;
    last_d = last_q;
    st_d   = st_q;
    pop_o  = 1'b0;
    rel_o  = '{en: 1'b0, bank: fifo_data_i.bank};
    if (load) begin
      unique case (fifo_data_i.kind)
        pmcf_pkg::K_PASS: begin
          byte_d = fifo_data_i.data;
          dv_d   = 1'b1;
          last_d = fifo_data_i.last;
          st_d   = pmcf_pkg::ST_OK;
          pop_o  = 1'b1;
        end
        pmcf_pkg::K_FLUSH: begin
          byte_d = hold_q[fifo_data_i.bank][idx_q];
          dv_d   = 1'b1;
          last_d = fifo_data_i.last & fl_end;
          st_d   = pmcf_pkg::ST_OK;
          if (fl_end) begin
            idx_d    = '0;
            pop_o    = 1'b1;
            rel_o.en = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          byte_d = '0;
          dv_d   = 1'b0;
          last_d = 1'b1;
          st_d   = fifo_data_i.status;
          pop_o  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    dv_q   <= dv_d;
    last_q <= last_d;
    st_q   <= st_d;
    if (hold_wr_i.en) begin
      hold_q[hold_wr_i.bank][hold_wr_i.idx] <= hold_wr_i.data;
    end
  end

  assign out_valid_o  = vld_q;
  assign out_byte_o   = byte_q;
  assign out_dvalid_o = dv_q;
  assign out_last_o   = last_q;
  assign out_status_o = st_q;

endmodule

/* sv/png_metadata_chunk_filter_unit.sv */
// top level of the png metadata chunk filter: front part, request queue, back part
// depends on pmcf_pkg, pmcf_front, pmcf_fifo, pmcf_back
//
// usage:
//   s_axis carries the png file one byte per request, tlast on its final byte.
//   m_axis carries the stripped file: tdata[7:0] byte, tdata[9:8] status,
//   tuser 1 for a data byte and 0 for a status-only item, tlast on the
//   final item of the file. a non-zero status (1 bad signature, 2 truncated
//   chunk) tells downstream to throw the file away.
//   eXIf, iCCP, iTXt, tEXt, zTXt and tIME chunks are removed, bytes after
//   IEND are discarded, a trailing fragment under 12 bytes is dropped.
//   throughput: one input byte per cycle. body bytes pass through the queue
//   and output register; the 8 signature bytes and each 12-byte chunk header
//   are held and sent one per cycle while m_axis is not stalled, from a
//   two-bank hold store; the input waits only when a new signature or header
//   would land in a bank still being sent or the four-entry queue is full.
//   reset clears the framing state, queue and output valid flag; the block
//   then expects a signature. a stall on m_axis holds the output item,
//   fills the queue and then drops s_axis_tready.
module png_metadata_chunk_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] out_status, rest zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] out_dvalid
);

  pmcf_pkg::q_ent_t    push_data, pop_data;
  pmcf_pkg::hold_wr_t  hold_wr;
  pmcf_pkg::bank_rel_t rel;
  logic push, pop, full, empty;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  pmcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .fifo_full_i (full),
    .push_o      (push),
    .push_data_o (push_data),
    .hold_wr_o   (hold_wr),
    .rel_i       (rel)
  );

  pmcf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  pmcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (empty),
    .fifo_data_i  (pop_data),
    .pop_o        (pop),
    .hold_wr_i    (hold_wr),
    .rel_o        (rel),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_dvalid_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'b0, out_status, out_byte};

endmodule

/* sv/pmcf_checker.sv */
// port-level checker for the png metadata chunk filter, bound to the top level
// depends on png_metadata_chunk_filter_unit_assert.svh
`include "png_metadata_chunk_filter_unit_assert.svh"

module pmcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  `PMCF_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

  `PMCF_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")

  `PMCF_ASSERT(a_status_item_last, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00, "status-only item not final")

  `PMCF_ASSERT(a_status_code, m_axis_tvalid && m_axis_tdata[9:8] != 2'b00 |-> m_axis_tlast && !m_axis_tuser && m_axis_tdata[9:8] != 2'b11, "bad status on output")

endmodule

bind png_metadata_chunk_filter_unit pmcf_checker u_pmcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
